// ===== sv/assert_macros.svh =====
// Assertion macros used by the RTL of the frame receiver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clk edge, off while reset is asserted.
`define ASSERT_IMPL(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// Condition that must never hold at a rising clk edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

// ===== sv/crc16fr_pkg.sv =====
// Package for the CRC-16 frame receiver: frame phase codes, register map, CRC update.
package crc16fr_pkg;

	// CRC-16/CCITT-FALSE constants
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	// Frame phase codes
	localparam int PH_W = 4;
	localparam logic [PH_W-1:0] PH_SYNC0   = 4'd0;
	localparam logic [PH_W-1:0] PH_SYNC1   = 4'd1;
	localparam logic [PH_W-1:0] PH_ID_LO   = 4'd2;
	localparam logic [PH_W-1:0] PH_ID_HI   = 4'd3;
	localparam logic [PH_W-1:0] PH_FLAGS   = 4'd4;
	localparam logic [PH_W-1:0] PH_SEQ     = 4'd5;
	localparam logic [PH_W-1:0] PH_LEN_LO  = 4'd6;
	localparam logic [PH_W-1:0] PH_LEN_HI  = 4'd7;
	localparam logic [PH_W-1:0] PH_PAYLOAD = 4'd8;
	localparam logic [PH_W-1:0] PH_CRC_HI  = 4'd9;
	localparam logic [PH_W-1:0] PH_CRC_LO  = 4'd10;

	// Register map: word index taken from paddr[3:2]
	localparam int ADDR_W = 4;
	localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
	localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
	localparam logic [1:0] REG_MAX_PAYLOAD = 2'd2;

	// Register reset values
	localparam logic [7:0]  SYNC_FIRST_RST  = 8'hAA;
	localparam logic [7:0]  SYNC_SECOND_RST = 8'h55;
	localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1024;

	// Result kinds
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_EOF     = 1'b1;

	// One byte into the CRC, MSB first: eight shift/xor steps
	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== sv/crc16_frame_receiver.sv =====
// Top level of the CRC-16 frame receiver: input register, frame state machine, result register.
// The receiver takes one byte per clock cycle and, when the result side does not stall,
// keeps that rate indefinitely. A byte is captured in an input register, where the frame
// state machine and a bytewise CRC-16/CCITT-FALSE update act on it; any result (a payload
// byte, or end of frame with the header fields and a CRC match flag) is loaded into the
// result register when the held byte moves on, which a stalled result register holds back.
// The eight-step CRC update is the longest path. Header, sync and high CRC bytes give no
// result, and the low CRC byte gives the end-of-frame result; frames whose declared length
// exceeds max_payload_bytes are dropped without a result.
// Registers sit at byte addresses 0, 4 and 8 (sync_first, sync_second, max_payload_bytes)
// and are meant to be written while no frame is in flight.
`include "assert_macros.svh"

module crc16_frame_receiver
	import crc16fr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// byte input channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        rx_byte,
	// result channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic              kind,
	output logic [7:0]        payload_byte,
	output logic [15:0]       packet_id,
	output logic [7:0]        frame_flags,
	output logic [7:0]        sequence_res,
	output logic [15:0]       length,
	output logic              crc_good,
	// configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	// configuration registers
	logic [7:0]  sync_first_q;
	logic [7:0]  sync_second_q;
	logic [15:0] max_payload_q;

	// input register
	logic        vld_s1;
	logic [7:0]  byte_s1;

	// frame state
	logic [PH_W-1:0] phase_q, phase_d;
	logic [15:0] crc_q, crc_d;
	logic [15:0] id_q, id_d;
	logic [7:0]  flags_q, flags_d;
	logic [7:0]  seq_q, seq_d;
	logic [15:0] len_q, len_d;
	logic [15:0] count_q, count_d;
	logic [7:0]  crc_hi_q, crc_hi_d;

	// result register
	logic        out_vld_q;
	logic        kind_q;
	logic [7:0]  data_q;
	logic [15:0] id_out_q;
	logic [7:0]  flags_out_q;
	logic [7:0]  seq_out_q;
	logic [15:0] len_out_q;
	logic        good_q;

	// step control
	logic        emit;
	logic        res_kind;
	logic        res_good;
	logic [7:0]  res_data;
	logic        out_free;
	logic        go;
	logic [15:0] crc_byte;
	logic [15:0] count_inc;
	logic        cfg_wr;

	// ---------------------------------------------------------------
	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= SYNC_FIRST_RST;
			sync_second_q <= SYNC_SECOND_RST;
			max_payload_q <= MAX_PAYLOAD_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_SYNC_FIRST:  sync_first_q  <= pwdata[7:0];
				REG_SYNC_SECOND: sync_second_q <= pwdata[7:0];
				REG_MAX_PAYLOAD: max_payload_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (paddr[3:2])
			REG_SYNC_FIRST:  prdata = {24'd0, sync_first_q};
			REG_SYNC_SECOND: prdata = {24'd0, sync_second_q};
			REG_MAX_PAYLOAD: prdata = {16'd0, max_payload_q};
			default:         prdata = 32'd0;
		endcase
	end

	// ---------------------------------------------------------------
	// Handshake: the held byte moves on unless it makes a result that
	// cannot be loaded this cycle
	assign out_free = !out_vld_q || !out_stall;
	assign go       = vld_s1 && (!emit || out_free);
	assign in_stall = vld_s1 && !go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!vld_s1 || go) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	// ---------------------------------------------------------------
	// Frame state machine and CRC update
	assign crc_byte  = crc_update(crc_q, byte_s1);
	assign count_inc = count_q + 16'd1;

	always_comb begin
		phase_d  = phase_q;
		crc_d    = crc_q;
		id_d     = id_q;
		flags_d  = flags_q;
		seq_d    = seq_q;
		len_d    = len_q;
		count_d  = count_q;
		crc_hi_d = crc_hi_q;
		emit     = 1'b0;
		res_kind = KIND_PAYLOAD;
		res_data = 8'd0;
		res_good = 1'b0;
		unique case (phase_q)
			PH_SYNC1: begin
				if (byte_s1 == sync_second_q) begin
					crc_d   = crc_byte;
					phase_d = PH_ID_LO;
				end else begin
					phase_d = PH_SYNC0;
				end
			end
			PH_ID_LO: begin
				crc_d   = crc_byte;
				id_d    = {8'd0, byte_s1};
				phase_d = PH_ID_HI;
			end
			PH_ID_HI: begin
				crc_d   = crc_byte;
				id_d    = {byte_s1, id_q[7:0]};
				phase_d = PH_FLAGS;
			end
			PH_FLAGS: begin
				crc_d   = crc_byte;
				flags_d = byte_s1;
				phase_d = PH_SEQ;
			end
			PH_SEQ: begin
				crc_d   = crc_byte;
				seq_d   = byte_s1;
				phase_d = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				crc_d   = crc_byte;
				len_d   = {8'd0, byte_s1};
				phase_d = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				crc_d   = crc_byte;
				len_d   = {byte_s1, len_q[7:0]};
				count_d = 16'd0;
				// oversized frames go back to the hunt without a result
				if (len_d > max_payload_q) begin
					phase_d = PH_SYNC0;
				end else if (len_d != 16'd0) begin
					phase_d = PH_PAYLOAD;
				end else begin
					phase_d = PH_CRC_HI;
				end
			end
			PH_PAYLOAD: begin
				crc_d    = crc_byte;
				count_d  = count_inc;
				emit     = 1'b1;
				res_kind = KIND_PAYLOAD;
				res_data = byte_s1;
				if (count_inc >= len_q) begin
					phase_d = PH_CRC_HI;
				end
			end
			PH_CRC_HI: begin
				crc_hi_d = byte_s1;
				phase_d  = PH_CRC_LO;
			end
			PH_CRC_LO: begin
				emit     = 1'b1;
				res_kind = KIND_EOF;
				res_good = ({crc_hi_q, byte_s1} == crc_q);
				phase_d  = PH_SYNC0;
			end
			default: begin
				// hunt for the first sync byte; unused codes act the same
				phase_d = PH_SYNC0;
				if (byte_s1 == sync_first_q) begin
					crc_d   = crc_update(CRC_INIT, byte_s1);
					count_d = 16'd0;
					phase_d = PH_SYNC1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SYNC0;
			crc_q    <= CRC_INIT;
			id_q     <= 16'd0;
			flags_q  <= 8'd0;
			seq_q    <= 8'd0;
			len_q    <= 16'd0;
			count_q  <= 16'd0;
			crc_hi_q <= 8'd0;
		end else if (go) begin
			phase_q  <= phase_d;
			crc_q    <= crc_d;
			id_q     <= id_d;
			flags_q  <= flags_d;
			seq_q    <= seq_d;
			len_q    <= len_d;
			count_q  <= count_d;
			crc_hi_q <= crc_hi_d;
		end
	end

	// ---------------------------------------------------------------
	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (go && emit) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && emit) begin
			kind_q      <= res_kind;
			data_q      <= res_data;
			id_out_q    <= id_q;
			flags_out_q <= flags_q;
			seq_out_q   <= seq_q;
			len_out_q   <= len_q;
			good_q      <= res_good;
		end
	end

	assign out_valid    = out_vld_q;
	assign kind         = kind_q;
	assign payload_byte = data_q;
	assign packet_id    = id_out_q;
	assign frame_flags  = flags_out_q;
	assign sequence_res = seq_out_q;
	assign length       = len_out_q;
	assign crc_good     = good_q;

	// ---------------------------------------------------------------
	// Assertions
	`ASSERT_NEVER(a_no_result_overwrite, go && emit && out_vld_q && out_stall,
		"result register overwritten while stalled")
	`ASSERT_IMPL(a_stall_only_when_held, in_stall, vld_s1,
		"input stalled with empty input register")
	`ASSERT_IMPL(a_count_below_length, phase_q == PH_PAYLOAD, count_q < len_q,
		"payload count reached declared length inside payload")
	`ASSERT_IMPL(a_payload_fields_clean, out_vld_q && (kind_q == KIND_PAYLOAD), !good_q,
		"crc_good set on a payload result")

endmodule
